/* rtl/srts_pkg.sv */
// Shared types and constants of the shortest-remaining-time task scheduler.
package srts_pkg;

  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED      = 3'd0,
    ST_FULL        = 3'd1,
    ST_ZERO_BURST  = 3'd2,
    ST_IDLE_TICK   = 3'd3,
    ST_RAN         = 3'd4,
    ST_FINISHED    = 3'd5
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_DRAIN  = 10'b0000000100,
    S_PICK   = 10'b0000001000,
    S_UPD    = 10'b0000010000,
    S_CALC_T = 10'b0000100000,
    S_CALC_W = 10'b0001000000,
    S_CALC_R = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } pick_ctl_t;

endpackage

/* rtl/shortest_remaining_tick_scheduler.sv */
// Top level of the preemptive shortest-remaining-time-first task scheduler.
// A load transaction, or a tick with no task loaded, goes from acceptance straight to the result stage.
// Otherwise a tick scans the N loaded slots one per cycle, picks the ready task with the least remaining
// time, runs it if one is ready and, when it finishes, computes turnaround, wait and response times.
// One transaction is in work at a time; a new one is taken once the result is registered.
// Reset clears the slot and finish counters and time; slot contents are unknown until loaded.
module shortest_remaining_tick_scheduler import srts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // task_id, arrive_at, burst_len
  input  logic [0:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // tick_at, ran_id, turnaround, wait_ticks, response, all_done
  output logic [2:0]  out_tuser   // status
);

  localparam int AA      = $clog2(MAX_TASKS);
  localparam int CW      = $clog2(MAX_TASKS + 1);
  localparam int XW      = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int ID_LO   = 0;
  localparam int ARR_LO  = FIELD_W;
  localparam int BUR_LO  = 2 * FIELD_W;
  localparam int LEFT_LO = 3 * FIELD_W;
  localparam int FR_LO   = 4 * FIELD_W;
  localparam int STD_BIT = 4 * FIELD_W + TIME_BITS;
  localparam int EW      = 4 * FIELD_W + TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  function automatic logic [FIELD_W-1:0] sat16(input logic [XW-1:0] v);
    if (v > XW'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return v[FIELD_W-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic [CW-1:0]        fin_r, fin_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 scan_vld_r;
  logic [AA-1:0]        scan_idx_r;
  logic                 out_valid_r, out_valid_nxt;

  status_t              res_status_r, res_status_nxt;
  logic [FIELD_W-1:0]   tick_r, tick_nxt;
  logic [FIELD_W-1:0]   ran_r, ran_nxt;
  logic [FIELD_W-1:0]   turn_r, turn_nxt;
  logic [FIELD_W-1:0]   wait_r, wait_nxt;
  logic [FIELD_W-1:0]   resp_r, resp_nxt;
  logic [XW-1:0]        t_r, t_nxt;
  logic [FIELD_W-1:0]   arr_r, arr_nxt;
  logic [FIELD_W-1:0]   burst_r, burst_nxt;
  logic [TIME_BITS-1:0] fr_r, fr_nxt;
  logic [2:0]           out_status_r;
  logic [87:0]          out_data_r;

  logic                 wr_en, rd_en;
  logic [AA-1:0]        wr_addr, rd_addr;
  logic [EW-1:0]        wr_data, rd_data, upd_entry;
  logic [FIELD_W-1:0]   in_id, in_arr, in_burst, new_left;
  logic [TIME_BITS-1:0] time_inc;
  logic [XW-1:0]        sub_a, sub_b;
  logic [XW:0]          diff;
  logic                 borrow, found, out_load;
  logic [AA-1:0]        pick_idx;
  pick_ctl_t            pctl;

  assign in_id    = in_tdata[15:0];
  assign in_arr   = in_tdata[31:16];
  assign in_burst = in_tdata[47:32];
  assign in_tready = (state_r == S_IDLE);
  assign time_inc  = (time_r == TIME_MAX) ? time_r : time_r + 1'b1;
  assign new_left  = rd_data[LEFT_LO +: FIELD_W] - 1'b1;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    case (state_r)
      S_CALC_T: begin
        sub_a = XW'(time_r);
        sub_b = XW'(arr_r);
      end
      S_CALC_W: begin
        sub_a = t_r;
        sub_b = XW'(burst_r);
      end
      default: begin
        sub_a = XW'(fr_r);
        sub_b = XW'(arr_r);
      end
    endcase
    diff   = {1'b0, sub_a} - {1'b0, sub_b};
    borrow = diff[XW];
  end

  always_comb begin
    upd_entry = rd_data;
    upd_entry[LEFT_LO +: FIELD_W] = new_left;
    if (!rd_data[STD_BIT]) begin
      upd_entry[STD_BIT] = 1'b1;
      upd_entry[FR_LO +: TIME_BITS] = time_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    fin_nxt        = fin_r;
    time_nxt       = time_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    tick_nxt       = tick_r;
    ran_nxt        = ran_r;
    turn_nxt       = turn_r;
    wait_nxt       = wait_r;
    resp_nxt       = resp_r;
    t_nxt          = t_r;
    arr_nxt        = arr_r;
    burst_nxt      = burst_r;
    fr_nxt         = fr_r;
    wr_en          = 1'b0;
    wr_addr        = used_r[AA-1:0];
    wr_data        = {1'b0, TIME_BITS'(0), in_burst, in_burst, in_arr, in_id};
    rd_en          = 1'b0;
    rd_addr        = idx_r[AA-1:0];
    pctl.clr       = 1'b0;
    pctl.vld       = scan_vld_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tick_nxt  = sat16(XW'(time_r));
          ran_nxt   = '0;
          turn_nxt  = '0;
          wait_nxt  = '0;
          resp_nxt  = '0;
          state_nxt = S_FIN;
          if (in_tuser[0] == REQ_LOAD) begin
            if (in_burst == '0) begin
              res_status_nxt = ST_ZERO_BURST;
            end else if (used_r >= CW'(MAX_TASKS)) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              used_nxt       = used_r + 1'b1;
              res_status_nxt = ST_LOADED;
            end
          end else if (used_r == '0) begin
            res_status_nxt = ST_IDLE_TICK;
            time_nxt       = time_inc;
          end else begin
            idx_nxt   = '0;
            pctl.clr  = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == used_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (!found) begin
          res_status_nxt = ST_IDLE_TICK;
          time_nxt       = time_inc;
          state_nxt      = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pick_idx;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        wr_en     = 1'b1;
        wr_addr   = pick_idx;
        wr_data   = upd_entry;
        time_nxt  = time_inc;
        ran_nxt   = rd_data[ID_LO +: FIELD_W];
        arr_nxt   = rd_data[ARR_LO +: FIELD_W];
        burst_nxt = rd_data[BUR_LO +: FIELD_W];
        fr_nxt    = upd_entry[FR_LO +: TIME_BITS];
        if (new_left == '0) begin
          fin_nxt        = fin_r + 1'b1;
          res_status_nxt = ST_FINISHED;
          state_nxt      = S_CALC_T;
        end else begin
          res_status_nxt = ST_RAN;
          state_nxt      = S_FIN;
        end
      end
      S_CALC_T: begin
        t_nxt     = diff[XW-1:0];
        turn_nxt  = sat16(diff[XW-1:0]);
        state_nxt = S_CALC_W;
      end
      S_CALC_W: begin
        wait_nxt  = borrow ? '0 : sat16(diff[XW-1:0]);
        state_nxt = S_CALC_R;
      end
      S_CALC_R: begin
        resp_nxt  = borrow ? '0 : sat16(diff[XW-1:0]);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fin_r       <= '0;
      time_r      <= '0;
      idx_r       <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fin_r       <= fin_nxt;
      time_r      <= time_nxt;
      idx_r       <= idx_nxt;
      scan_vld_r  <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= idx_r[AA-1:0];
    res_status_r <= res_status_nxt;
    tick_r       <= tick_nxt;
    ran_r        <= ran_nxt;
    turn_r       <= turn_nxt;
    wait_r       <= wait_nxt;
    resp_r       <= resp_nxt;
    t_r          <= t_nxt;
    arr_r        <= arr_nxt;
    burst_r      <= burst_nxt;
    fr_r         <= fr_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= {7'b0, (fin_r == used_r), resp_r, wait_r, turn_r, ran_r, tick_r};
    end
  end

  srts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srts_pick #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (pctl),
    .slot_idx     (scan_idx_r),
    .slot_arrival (rd_data[ARR_LO +: FIELD_W]),
    .slot_left    (rd_data[LEFT_LO +: FIELD_W]),
    .time_now     (time_r),
    .found        (found),
    .pick_idx     (pick_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/srts_ram.sv */
// Generic single-write, single-read memory with registered read data.
module srts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/srts_pick.sv */
// Running minimum search over the task table, one slot per cycle.
module srts_pick import srts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pick_ctl_t                    ctl,
  input  logic [$clog2(MAX_TASKS)-1:0] slot_idx,
  input  logic [FIELD_W-1:0]           slot_arrival,
  input  logic [FIELD_W-1:0]           slot_left,
  input  logic [TIME_BITS-1:0]         time_now,
  output logic                         found,
  output logic [$clog2(MAX_TASKS)-1:0] pick_idx
);

  localparam int AA = $clog2(MAX_TASKS);
  localparam int XW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  logic               found_r, found_nxt;
  logic [FIELD_W-1:0] best_r, best_nxt;
  logic [AA-1:0]      pick_r, pick_nxt;
  logic               take;

  assign take = ctl.vld && (XW'(slot_arrival) <= XW'(time_now)) && (slot_left != '0) &&
                (!found_r || (slot_left < best_r));

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
      best_nxt  = slot_left;
      pick_nxt  = slot_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    pick_r <= pick_nxt;
  end

  assign found    = found_r;
  assign pick_idx = pick_r;

endmodule
